// ===== rtl/cpt_pkg.sv =====
// ----------------------------------------------------------------------------
// cpt_pkg: shared types and constants of the prescaled timer bank
// Request codes, control word layout, prescale table and per-timer control.
// ----------------------------------------------------------------------------
package cpt_pkg;

    // Default sizes of the bank.
    localparam int NUM_TIMERS_DEF    = 4;
    localparam int COUNTER_WIDTH_DEF = 16;

    // Fixed field widths.
    localparam int REQ_W    = 2;
    localparam int SEL_W    = 2;
    localparam int DATA_W   = 16;
    localparam int MASK_W   = 4;
    localparam int CYCLE_W  = 14;
    localparam int EXTRA_W  = 3;
    localparam int SHIFT_W  = 4;

    // Largest extra prescale that takes effect.
    localparam logic [EXTRA_W-1:0] EXTRA_MAX = 3'd4;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_TICK       = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WR_RELOAD  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_WR_CONTROL = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ       = 2'd3;

    // Control word bit positions.
    localparam int CTL_PRESC_LO = 0;
    localparam int CTL_CASCADE  = 2;
    localparam int CTL_IRQ_EN   = 6;
    localparam int CTL_ENABLE   = 7;

    // Per-timer control for one request moving through the compute stage.
    typedef struct packed {
        logic advance;
        logic tick;
        logic wr_reload;
        logic wr_control;
        logic sel_hit;
        logic cascade_allow;
    } t_timer_ctl;

    // Prescale shift for a two-bit select.
    function automatic logic [SHIFT_W-1:0] prescale_shift(input logic [1:0] sel);
        logic [SHIFT_W-1:0] sh;
        unique case (sel)
            2'd0:    sh = 4'd0;
            2'd1:    sh = 4'd6;
            2'd2:    sh = 4'd8;
            default: sh = 4'd10;
        endcase
        return sh;
    endfunction

    // Mask of the low sh bits of the cycle counter.
    function automatic logic [CYCLE_W-1:0] prescale_mask(input logic [SHIFT_W-1:0] sh);
        logic [CYCLE_W-1:0] m;
        for (int b = 0; b < CYCLE_W; b++) begin
            m[b] = (SHIFT_W'(b) < sh);
        end
        return m;
    endfunction

endpackage

// ===== rtl/cpt_ifs.sv =====
// ----------------------------------------------------------------------------
// cpt_ifs: request and response channels of the timer bank
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface cpt_req_if;
    logic                       valid;
    logic                       ready;
    logic [cpt_pkg::REQ_W-1:0]  req_type;
    logic [cpt_pkg::SEL_W-1:0]  timer_select;
    logic [cpt_pkg::DATA_W-1:0] write_data;

    modport source (output valid, output req_type, output timer_select,
                    output write_data, input ready);
    modport sink   (input valid, input req_type, input timer_select,
                    input write_data, output ready);
endinterface

interface cpt_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [cpt_pkg::DATA_W-1:0] read_data;
    logic [cpt_pkg::MASK_W-1:0] overflow_mask;
    logic [cpt_pkg::MASK_W-1:0] irq_mask;

    modport source (output valid, output read_data, output overflow_mask,
                    output irq_mask, input ready);
    modport sink   (input valid, input read_data, input overflow_mask,
                    input irq_mask, output ready);
endinterface

// ===== rtl/cpt_in_stage.sv =====
// ----------------------------------------------------------------------------
// cpt_in_stage: input register of the timer bank
// Holds one request until the compute stage takes it.
// ----------------------------------------------------------------------------
module cpt_in_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    cpt_req_if.sink                    i_req,
    input  logic                       i_advance,
    output logic                       o_valid,
    output logic [cpt_pkg::REQ_W-1:0]  o_req_type,
    output logic [cpt_pkg::SEL_W-1:0]  o_timer_select,
    output logic [cpt_pkg::DATA_W-1:0] o_write_data
);

    logic                       r_valid;
    logic [cpt_pkg::REQ_W-1:0]  r_req_type;
    logic [cpt_pkg::SEL_W-1:0]  r_timer_select;
    logic [cpt_pkg::DATA_W-1:0] r_write_data;
    logic                       w_take;

    // The register frees up in the same cycle its request moves on.
    assign i_req.ready = !r_valid || i_advance;
    assign w_take      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req_type     <= i_req.req_type;
            r_timer_select <= i_req.timer_select;
            r_write_data   <= i_req.write_data;
        end
    end

    assign o_valid        = r_valid;
    assign o_req_type     = r_req_type;
    assign o_timer_select = r_timer_select;
    assign o_write_data   = r_write_data;

endmodule

// ===== rtl/cpt_timer.sv =====
// ----------------------------------------------------------------------------
// cpt_timer: one counter of the bank with its reload and control state
// Counts on prescaled cycles or on the overflow of the timer below it.
// ----------------------------------------------------------------------------
module cpt_timer #(
    parameter int COUNTER_WIDTH = cpt_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cpt_pkg::t_timer_ctl          i_ctl,
    input  logic [COUNTER_WIDTH-1:0]     i_data,
    input  logic [cpt_pkg::DATA_W-1:0]   i_ctl_word,
    input  logic [cpt_pkg::CYCLE_W-1:0]  i_cycle_next,
    input  logic [cpt_pkg::EXTRA_W-1:0]  i_extra,
    input  logic                         i_carry_in,
    output logic                         o_overflow,
    output logic                         o_irq_enable,
    output logic [COUNTER_WIDTH-1:0]     o_count
);

    logic [COUNTER_WIDTH-1:0] r_count;
    logic [COUNTER_WIDTH-1:0] r_reload;
    logic [1:0]               r_presc;
    logic                     r_cascade;
    logic                     r_irq_en;
    logic                     r_run;

    logic [cpt_pkg::SHIFT_W-1:0] w_shift;
    logic [cpt_pkg::CYCLE_W-1:0] w_mask;
    logic                        w_presc_hit;
    logic                        w_inc;
    logic                        w_of;
    logic                        w_ctl_write;
    logic                        w_new_run;

    // Prescaled increment: the low bits of the advanced cycle counter are zero.
    assign w_shift     = cpt_pkg::prescale_shift(r_presc)
                         + {1'b0, i_extra};
    assign w_mask      = cpt_pkg::prescale_mask(w_shift);
    assign w_presc_hit = (i_cycle_next & w_mask) == '0;

    assign w_inc = r_run && (r_cascade ? i_carry_in : w_presc_hit);
    assign w_of  = w_inc && (&r_count);

    assign w_ctl_write = i_ctl.advance && i_ctl.wr_control && i_ctl.sel_hit;
    assign w_new_run   = i_ctl_word[cpt_pkg::CTL_ENABLE];

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc   <= '0;
            r_cascade <= 1'b0;
            r_irq_en  <= 1'b0;
            r_run     <= 1'b0;
        end else if (w_ctl_write) begin
            r_presc   <= i_ctl_word[cpt_pkg::CTL_PRESC_LO +: 2];
            r_cascade <= i_ctl_word[cpt_pkg::CTL_CASCADE] && i_ctl.cascade_allow;
            r_irq_en  <= i_ctl_word[cpt_pkg::CTL_IRQ_EN];
            r_run     <= w_new_run;
        end
    end

    // Reload value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload <= '0;
        end else if (i_ctl.advance && i_ctl.wr_reload && i_ctl.sel_hit) begin
            r_reload <= i_data;
        end
    end

    // Counter: ticks count or reload on overflow; enabling loads the reload value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.advance && i_ctl.tick && w_inc) begin
            r_count <= w_of ? r_reload : r_count + 1'b1;
        end else if (w_ctl_write && !r_run && w_new_run) begin
            r_count <= r_reload;
        end
    end

    assign o_overflow   = i_ctl.tick && w_of;
    assign o_irq_enable = r_irq_en;
    assign o_count      = r_count;

endmodule

// ===== rtl/cpt_out_stage.sv =====
// ----------------------------------------------------------------------------
// cpt_out_stage: result register of the timer bank
// Holds one response until the consumer takes it.
// ----------------------------------------------------------------------------
module cpt_out_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic [cpt_pkg::DATA_W-1:0] i_read_data,
    input  logic [cpt_pkg::MASK_W-1:0] i_overflow_mask,
    input  logic [cpt_pkg::MASK_W-1:0] i_irq_mask,
    output logic                       o_free,
    cpt_rsp_if.source                  o_rsp
);

    logic                       r_valid;
    logic [cpt_pkg::DATA_W-1:0] r_read_data;
    logic [cpt_pkg::MASK_W-1:0] r_overflow_mask;
    logic [cpt_pkg::MASK_W-1:0] r_irq_mask;

    // Free when empty or when the held response leaves this cycle.
    assign o_free = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_read_data     <= i_read_data;
            r_overflow_mask <= i_overflow_mask;
            r_irq_mask      <= i_irq_mask;
        end
    end

    assign o_rsp.valid         = r_valid;
    assign o_rsp.read_data     = r_read_data;
    assign o_rsp.overflow_mask = r_overflow_mask;
    assign o_rsp.irq_mask      = r_irq_mask;

endmodule

// ===== rtl/cascadable_prescaled_timer_bank.sv =====
// ----------------------------------------------------------------------------
// cascadable_prescaled_timer_bank: bank of cascadable prescaled up-counters
// Ticks, reload writes, control writes and counter reads, one response each.
//
//   Channel   Dir   Signals                                        Moves when
//   i_req     in    req_type, timer_select, write_data             valid&ready
//   o_rsp     out   read_data, overflow_mask, irq_mask             valid&ready
//   cfg       in    i_cfg_we, i_cfg_wdata (extra_prescale)         i_cfg_we
//
// One request per cycle is sustained while responses are taken; a response is
// presented once its request moves from the input register into the result
// register. The whole cascade chain settles in the single compute stage between
// them. Reset is synchronous and clears all timer state, the cycle counter and
// extra_prescale; no clearing pass is needed. A stalled response holds the
// result register and, one request later, the input register.
// ----------------------------------------------------------------------------
module cascadable_prescaled_timer_bank #(
    parameter int NUM_TIMERS    = cpt_pkg::NUM_TIMERS_DEF,
    parameter int COUNTER_WIDTH = cpt_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cpt_pkg::EXTRA_W-1:0] i_cfg_wdata,
    cpt_req_if.sink                     i_req,
    cpt_rsp_if.source                   o_rsp
);

    localparam int MASK_TIMERS = (NUM_TIMERS < cpt_pkg::MASK_W) ? NUM_TIMERS
                                                                 : cpt_pkg::MASK_W;

    logic                        w_in_valid;
    logic [cpt_pkg::REQ_W-1:0]   w_req_type;
    logic [cpt_pkg::SEL_W-1:0]   w_sel;
    logic [cpt_pkg::DATA_W-1:0]  w_wdata;
    logic                        w_out_free;
    logic                        w_advance;
    logic                        w_is_tick;

    logic [cpt_pkg::EXTRA_W-1:0] r_extra_prescale;
    logic [cpt_pkg::EXTRA_W-1:0] w_extra;
    logic [cpt_pkg::CYCLE_W-1:0] r_cycle;
    logic [cpt_pkg::CYCLE_W-1:0] n_cycle;

    logic [NUM_TIMERS:0]         w_carry;
    logic [NUM_TIMERS-1:0]       w_of;
    logic [NUM_TIMERS-1:0]       w_irq_en;
    logic [NUM_TIMERS-1:0]       w_hit;
    logic [COUNTER_WIDTH-1:0]    w_count [NUM_TIMERS];

    logic [cpt_pkg::DATA_W-1:0]  w_read_data;
    logic [cpt_pkg::MASK_W-1:0]  w_ovf_mask;
    logic [cpt_pkg::MASK_W-1:0]  w_irq_mask;

    // Input register.
    cpt_in_stage u_in (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .i_advance      (w_advance),
        .o_valid        (w_in_valid),
        .o_req_type     (w_req_type),
        .o_timer_select (w_sel),
        .o_write_data   (w_wdata)
    );

    // A request is processed when it can land in the result register.
    assign w_advance = w_in_valid && w_out_free;
    assign w_is_tick = (w_req_type == cpt_pkg::REQ_TICK);

    // Extra prescale register, clamped on use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extra_prescale <= '0;
        end else if (i_cfg_we) begin
            r_extra_prescale <= i_cfg_wdata;
        end
    end

    assign w_extra = (r_extra_prescale > cpt_pkg::EXTRA_MAX) ? cpt_pkg::EXTRA_MAX
                                                             : r_extra_prescale;

    // Cycle counter, advanced by every processed tick.
    assign n_cycle = r_cycle + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle <= '0;
        end else if (w_advance && w_is_tick) begin
            r_cycle <= n_cycle;
        end
    end

    // Timers, chained through their overflow carries.
    assign w_carry[0] = 1'b0;

    for (genvar gi = 0; gi < NUM_TIMERS; gi++) begin : g_timer
        cpt_pkg::t_timer_ctl w_ctl;

        assign w_hit[gi]           = ({1'b0, w_sel} == (cpt_pkg::SEL_W + 1)'(gi));
        assign w_ctl.advance       = w_advance;
        assign w_ctl.tick          = w_is_tick;
        assign w_ctl.wr_reload     = (w_req_type == cpt_pkg::REQ_WR_RELOAD);
        assign w_ctl.wr_control    = (w_req_type == cpt_pkg::REQ_WR_CONTROL);
        assign w_ctl.sel_hit       = w_hit[gi];
        assign w_ctl.cascade_allow = (gi != 0);

        cpt_timer #(
            .COUNTER_WIDTH (COUNTER_WIDTH)
        ) u_timer (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_data       (COUNTER_WIDTH'(w_wdata)),
            .i_ctl_word   (w_wdata),
            .i_cycle_next (n_cycle),
            .i_extra      (w_extra),
            .i_carry_in   (w_carry[gi]),
            .o_overflow   (w_of[gi]),
            .o_irq_enable (w_irq_en[gi]),
            .o_count      (w_count[gi])
        );

        assign w_carry[gi+1] = w_of[gi];
    end

    // Overflow and interrupt masks cover the first four timers only.
    for (genvar gm = 0; gm < cpt_pkg::MASK_W; gm++) begin : g_mask
        if (gm < MASK_TIMERS) begin : g_used
            assign w_ovf_mask[gm] = w_of[gm];
            assign w_irq_mask[gm] = w_of[gm] && w_irq_en[gm];
        end else begin : g_unused
            assign w_ovf_mask[gm] = 1'b0;
            assign w_irq_mask[gm] = 1'b0;
        end
    end

    // Counter read: selected timer, zero when the select matches no timer.
    always_comb begin
        w_read_data = '0;
        if (w_req_type == cpt_pkg::REQ_READ) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                if (w_hit[i]) begin
                    w_read_data = w_read_data | cpt_pkg::DATA_W'(w_count[i]);
                end
            end
        end
    end

    // Result register.
    cpt_out_stage u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_advance),
        .i_read_data     (w_read_data),
        .i_overflow_mask (w_ovf_mask),
        .i_irq_mask      (w_irq_mask),
        .o_free          (w_out_free),
        .o_rsp           (o_rsp)
    );

endmodule

// ===== rtl/cpt_checker.sv =====
// ----------------------------------------------------------------------------
// cpt_checker: port-level checks of the timer bank
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module cpt_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_req_valid,
    input logic                       i_req_ready,
    input logic                       i_rsp_valid,
    input logic                       i_rsp_ready,
    input logic [cpt_pkg::DATA_W-1:0] i_read_data,
    input logic [cpt_pkg::MASK_W-1:0] i_overflow_mask,
    input logic [cpt_pkg::MASK_W-1:0] i_irq_mask
);

    // A stalled response holds its value.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_read_data)
            && $stable(i_overflow_mask) && $stable(i_irq_mask))
        else $error("response changed while stalled");

    // The bank only refuses a request when a response is stalled.
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req_ready |-> i_rsp_valid && !i_rsp_ready)
        else $error("request refused without a stalled response");

    // After reset both registers are empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid && i_req_ready)
        else $error("bank not empty after reset");

    // An interrupt is only raised by a timer that overflowed.
    a_irq_in_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_irq_mask & ~i_overflow_mask) == '0)
        else $error("interrupt without overflow");

endmodule

bind cascadable_prescaled_timer_bank cpt_checker u_cpt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_read_data     (o_rsp.read_data),
    .i_overflow_mask (o_rsp.overflow_mask),
    .i_irq_mask      (o_rsp.irq_mask)
);
